### rtl/mktr_pkg.sv
package mktr_pkg;

  localparam int DEF_MAX_LEAVES = 16;
  localparam int HASH_BYTES     = 32;
  localparam int NODE_WORDS     = HASH_BYTES / 8;
  localparam int WORD_W         = 64;
  localparam int HEIGHT_W       = 3;
  localparam int SEL_W          = 4;
  localparam int LEVEL_W        = 3;
  localparam int CFG_DATA_W     = 4;
  localparam int CFG_IDX_W      = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LEAF_COUNT_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECTED_LEAF   = 1'd1;

  localparam logic [HEIGHT_W-1:0] RST_LEAF_COUNT_LOG2 = 3'd4;
  localparam logic [SEL_W-1:0]    RST_SELECTED_LEAF   = 4'd0;

  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0]  digest_t;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // padding block for a 64-byte message: 0x80 marker, bit length 512
  function automatic block_t pad_block();
    block_t b;
    b     = '0;
    b[0]  = 32'h80000000;
    b[15] = 32'd512;
    return b;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_LEAF,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_EMIT,
    ST_H1_GO,
    ST_H1_WAIT,
    ST_H2_GO,
    ST_H2_WAIT,
    ST_WR_NODE
  } ctrl_state_e;

  typedef struct packed {
    logic       leaf_load;
    logic       ram_we;
    logic       ram_re;
    logic       wr_digest;
    logic [2:0] word_sel;
    logic       cap_out;
    logic       cap_msg;
    logic       sha_start;
    logic       sha_first;
  } dp_cmd_t;

  typedef struct packed {
    logic sha_done;
  } dp_stat_t;

endpackage

### rtl/mktr_leaf_if.sv
interface mktr_leaf_if;
  logic        valid;
  logic        ready;
  logic [63:0] leaf_word0;
  logic [63:0] leaf_word1;
  logic [63:0] leaf_word2;
  logic [63:0] leaf_word3;

  modport source (output valid, leaf_word0, leaf_word1, leaf_word2, leaf_word3,
                  input ready);
  modport sink (input valid, leaf_word0, leaf_word1, leaf_word2, leaf_word3,
                output ready);
endinterface

### rtl/mktr_node_if.sv
interface mktr_node_if;
  logic        valid;
  logic        ready;
  logic [63:0] node_word0;
  logic [63:0] node_word1;
  logic [63:0] node_word2;
  logic [63:0] node_word3;
  logic [2:0]  node_level;
  logic        is_root;

  modport source (output valid, node_word0, node_word1, node_word2, node_word3,
                  node_level, is_root, input ready);
  modport sink (input valid, node_word0, node_word1, node_word2, node_word3,
                node_level, is_root, output ready);
endinterface

### rtl/mktr_ram.sv
module mktr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mktr_sha_core.sv
module mktr_sha_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             first_i,
  input  mktr_pkg::block_t block_i,
  output logic             done_o,
  output mktr_pkg::digest_t digest_o
);

  logic [7:0][31:0]  st_q, st_d;
  mktr_pkg::digest_t hv_q, hv_d;
  logic [15:0][31:0] w_q, w_d;
  logic [5:0]        rnd_q, rnd_d;
  logic              busy_q, busy_d, fin_q, fin_d, done_q, done_d;

  logic [31:0] t1, t2, s0, s1, big0, big1, ch, maj;

  always_comb begin
    big1 = {st_q[4][5:0], st_q[4][31:6]} ^ {st_q[4][10:0], st_q[4][31:11]}
         ^ {st_q[4][24:0], st_q[4][31:25]};
    ch   = (st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]);
    big0 = {st_q[0][1:0], st_q[0][31:2]} ^ {st_q[0][12:0], st_q[0][31:13]}
         ^ {st_q[0][21:0], st_q[0][31:22]};
    maj  = (st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]);
    t1   = st_q[7] + big1 + ch + mktr_pkg::SHA_K[rnd_q] + w_q[0];
    t2   = big0 + maj;
    s0   = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
         ^ (w_q[1] >> 3);
    s1   = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
  end

  always_comb begin
    st_d   = st_q;
    hv_d   = hv_q;
    w_d    = w_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    done_d = 1'b0;
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        hv_d[i] = first_i ? mktr_pkg::SHA_IV[i] : hv_q[i];
        st_d[i] = first_i ? mktr_pkg::SHA_IV[i] : hv_q[i];
      end
      w_d    = block_i;
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      st_d[7] = st_q[6];
      st_d[6] = st_q[5];
      st_d[5] = st_q[4];
      st_d[4] = st_q[3] + t1;
      st_d[3] = st_q[2];
      st_d[2] = st_q[1];
      st_d[1] = st_q[0];
      st_d[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = w_q[0] + s0 + w_q[9] + s1;
      rnd_d   = rnd_q + 6'd1;
      if (rnd_q == 6'd63) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end else if (fin_q) begin
      for (int i = 0; i < 8; i++) begin
        hv_d[i] = hv_q[i] + st_q[i];
      end
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    hv_q <= hv_d;
    w_q  <= w_d;
  end

  assign done_o   = done_q;
  assign digest_o = hv_q;

endmodule

### rtl/mktr_datapath.sv
module mktr_datapath #(
  parameter int MAX_LEAVES = mktr_pkg::DEF_MAX_LEAVES,
  parameter int AW         = $clog2(MAX_LEAVES * mktr_pkg::NODE_WORDS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mktr_pkg::dp_cmd_t       cmd_i,
  input  logic [AW-1:0]           addr_i,
  input  logic [3:0][63:0]        leaf_word_i,
  output mktr_pkg::dp_stat_t      stat_o,
  output logic [3:0][63:0]        node_word_o
);

  logic [3:0][63:0]  leaf_q, out_q;
  logic [15:0][31:0] msg_q;
  logic [63:0]       wdata, rdata;
  mktr_pkg::digest_t digest;
  mktr_pkg::block_t  block;
  logic              sha_done;
  logic [3:0]        msg_hi;

  assign wdata = cmd_i.wr_digest
               ? {digest[{cmd_i.word_sel[1:0], 1'b0}], digest[{cmd_i.word_sel[1:0], 1'b1}]}
               : leaf_q[cmd_i.word_sel[1:0]];

  mktr_ram #(
    .WIDTH (mktr_pkg::WORD_W),
    .DEPTH (MAX_LEAVES * mktr_pkg::NODE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .re_i    (cmd_i.ram_re),
    .addr_i  (addr_i),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign block  = cmd_i.sha_first ? msg_q : mktr_pkg::pad_block();
  assign msg_hi = {cmd_i.word_sel, 1'b0};

  mktr_sha_core u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.sha_start),
    .first_i  (cmd_i.sha_first),
    .block_i  (block),
    .done_o   (sha_done),
    .digest_o (digest)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.leaf_load) begin
      leaf_q <= leaf_word_i;
    end
    if (cmd_i.cap_out) begin
      out_q[cmd_i.word_sel[1:0]] <= rdata;
    end
    if (cmd_i.cap_msg) begin
      msg_q[msg_hi]        <= rdata[63:32];
      msg_q[msg_hi | 4'd1] <= rdata[31:0];
    end
  end

  assign stat_o.sha_done = sha_done;
  assign node_word_o     = out_q;

endmodule

### rtl/mktr_ctrl.sv
module mktr_ctrl #(
  parameter int MAX_LEAVES = mktr_pkg::DEF_MAX_LEAVES,
  parameter int AW         = $clog2(MAX_LEAVES * mktr_pkg::NODE_WORDS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mktr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mktr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mktr_pkg::LEVEL_W-1:0]        out_level_o,
  output logic                                out_root_o,
  output mktr_pkg::dp_cmd_t                   cmd_o,
  output logic [AW-1:0]                       addr_o,
  input  mktr_pkg::dp_stat_t                  stat_i
);

  localparam int MaxH   = $clog2(MAX_LEAVES + 1) - 1;
  localparam int LD_W   = $clog2(MAX_LEAVES + 1);
  localparam int LEAF_W = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;

  mktr_pkg::ctrl_state_e state_q, state_d;

  logic [mktr_pkg::HEIGHT_W-1:0] hcfg_q, height;
  logic [mktr_pkg::SEL_W-1:0]    sel_q;
  logic [LD_W-1:0]               loaded_q, loaded_d, count, nodes;
  logic [LD_W:0]                 loaded_inc;
  logic [2:0]                    wcnt_q, wcnt_d;
  logic [mktr_pkg::LEVEL_W-1:0]  lvl_q, lvl_d;
  logic [LEAF_W-1:0]             idx_q, idx_d, pair_q, pair_d, mask;
  logic                          root_q, root_d, rdmsg_q, rdmsg_d;
  logic                          leaf_last, rd_last, tree_full, pair_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcfg_q <= mktr_pkg::RST_LEAF_COUNT_LOG2;
      sel_q  <= mktr_pkg::RST_SELECTED_LEAF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mktr_pkg::REG_LEAF_COUNT_LOG2: hcfg_q <= cfg_data_i[mktr_pkg::HEIGHT_W-1:0];
        mktr_pkg::REG_SELECTED_LEAF:   sel_q  <= cfg_data_i[mktr_pkg::SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign height     = (int'(hcfg_q) > MaxH) ? mktr_pkg::HEIGHT_W'(MaxH) : hcfg_q;
  assign count      = LD_W'(1) << height;
  assign mask       = LEAF_W'(count - LD_W'(1));
  assign nodes      = count >> (lvl_q + 3'd1);
  assign loaded_inc = {1'b0, loaded_q} + (LD_W + 1)'(1);
  assign tree_full  = loaded_inc >= {1'b0, count};
  assign leaf_last  = wcnt_q == 3'd3;
  assign rd_last    = rdmsg_q ? (wcnt_q == 3'd7) : (wcnt_q == 3'd3);
  assign pair_last  = (LD_W'(pair_q) + LD_W'(1)) == nodes;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mktr_pkg::ST_IDLE:    if (in_valid_i) state_d = mktr_pkg::ST_WR_LEAF;
      mktr_pkg::ST_WR_LEAF: if (leaf_last) begin
        state_d = tree_full ? mktr_pkg::ST_RD_ADDR : mktr_pkg::ST_IDLE;
      end
      mktr_pkg::ST_RD_ADDR: state_d = mktr_pkg::ST_RD_DATA;
      mktr_pkg::ST_RD_DATA: if (rd_last) begin
        state_d = rdmsg_q ? mktr_pkg::ST_H1_GO : mktr_pkg::ST_EMIT;
      end else begin
        state_d = mktr_pkg::ST_RD_ADDR;
      end
      mktr_pkg::ST_EMIT:    if (out_ready_i) begin
        state_d = root_q ? mktr_pkg::ST_IDLE : mktr_pkg::ST_RD_ADDR;
      end
      mktr_pkg::ST_H1_GO:   state_d = mktr_pkg::ST_H1_WAIT;
      mktr_pkg::ST_H1_WAIT: if (stat_i.sha_done) state_d = mktr_pkg::ST_H2_GO;
      mktr_pkg::ST_H2_GO:   state_d = mktr_pkg::ST_H2_WAIT;
      mktr_pkg::ST_H2_WAIT: if (stat_i.sha_done) state_d = mktr_pkg::ST_WR_NODE;
      mktr_pkg::ST_WR_NODE: if (leaf_last) state_d = mktr_pkg::ST_RD_ADDR;
      default:              state_d = mktr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    addr_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    loaded_d    = loaded_q;
    wcnt_d      = wcnt_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    pair_d      = pair_q;
    root_d      = root_q;
    rdmsg_d     = rdmsg_q;
    cmd_o.word_sel = wcnt_q;
    unique case (state_q)
      mktr_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.leaf_load = in_valid_i;
        wcnt_d          = '0;
      end
      mktr_pkg::ST_WR_LEAF: begin
        cmd_o.ram_we = int'(loaded_q) < MAX_LEAVES;
        addr_o       = AW'({loaded_q[LEAF_W-1:0], wcnt_q[1:0]});
        wcnt_d       = wcnt_q + 3'd1;
        if (leaf_last) begin
          wcnt_d = '0;
          if (int'(loaded_q) < MAX_LEAVES) begin
            loaded_d = loaded_inc[LD_W-1:0];
          end
          lvl_d   = '0;
          idx_d   = LEAF_W'(sel_q) & mask;
          root_d  = height == '0;
          rdmsg_d = 1'b0;
        end
      end
      mktr_pkg::ST_RD_ADDR: begin
        cmd_o.ram_re = 1'b1;
        if (rdmsg_q) begin
          addr_o = AW'({pair_q, wcnt_q});
        end else if (root_q) begin
          addr_o = AW'(wcnt_q[1:0]);
        end else begin
          addr_o = AW'({idx_q ^ LEAF_W'(1), wcnt_q[1:0]});
        end
      end
      mktr_pkg::ST_RD_DATA: begin
        cmd_o.cap_msg = rdmsg_q;
        cmd_o.cap_out = !rdmsg_q;
        wcnt_d        = rd_last ? 3'd0 : wcnt_q + 3'd1;
      end
      mktr_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (root_q) begin
            loaded_d = '0;
          end
          pair_d  = '0;
          rdmsg_d = 1'b1;
        end
      end
      mktr_pkg::ST_H1_GO: begin
        cmd_o.sha_start = 1'b1;
        cmd_o.sha_first = 1'b1;
      end
      mktr_pkg::ST_H1_WAIT: ;
      mktr_pkg::ST_H2_GO:   cmd_o.sha_start = 1'b1;
      mktr_pkg::ST_H2_WAIT: wcnt_d = '0;
      mktr_pkg::ST_WR_NODE: begin
        cmd_o.ram_we    = 1'b1;
        cmd_o.wr_digest = 1'b1;
        addr_o          = AW'({pair_q, wcnt_q[1:0]});
        wcnt_d          = wcnt_q + 3'd1;
        if (leaf_last) begin
          wcnt_d = '0;
          if (pair_last) begin
            // level done: next comes the sibling one level up, or the root
            pair_d  = '0;
            lvl_d   = lvl_q + 3'd1;
            idx_d   = idx_q >> 1;
            root_d  = (lvl_q + 3'd1) == height;
            rdmsg_d = 1'b0;
          end else begin
            pair_d = pair_q + LEAF_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mktr_pkg::ST_IDLE;
      loaded_q <= '0;
      wcnt_q   <= '0;
      lvl_q    <= '0;
      idx_q    <= '0;
      pair_q   <= '0;
      root_q   <= 1'b0;
      rdmsg_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      wcnt_q   <= wcnt_d;
      lvl_q    <= lvl_d;
      idx_q    <= idx_d;
      pair_q   <= pair_d;
      root_q   <= root_d;
      rdmsg_q  <= rdmsg_d;
    end
  end

  assign out_level_o = lvl_q;
  assign out_root_o  = root_q;

endmodule

### rtl/merkle_tree_root_and_auth_path.sv
// Channel  | Dir | Payload                                     | Transaction
// leaf_i   | in  | leaf_word0..3                               | one leaf hash
// node_o   | out | node_word0..3, node_level, is_root          | path sibling or root
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i             | register write
//
// The last leaf of a tree starts the build: each parent costs 8 store reads,
// two passes of the single SHA-256 round unit and 4 store writes. Each emitted
// node costs 4 store reads and then waits on node_o.ready; no leaf is taken
// until the root has gone.
// Reset returns control and configuration to their reset values; the node store is not cleared.
module merkle_tree_root_and_auth_path #(
  parameter int MAX_LEAVES = mktr_pkg::DEF_MAX_LEAVES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mktr_leaf_if.sink                       leaf_i,
  mktr_node_if.source                     node_o,
  input  logic                            cfg_we_i,
  input  logic [mktr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mktr_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_LEAVES * mktr_pkg::NODE_WORDS);

  mktr_pkg::dp_cmd_t  cmd;
  mktr_pkg::dp_stat_t stat;
  logic [AW-1:0]      addr;
  logic [3:0][63:0]   leaf_word, node_word;

  assign leaf_word = {leaf_i.leaf_word3, leaf_i.leaf_word2,
                      leaf_i.leaf_word1, leaf_i.leaf_word0};

  mktr_ctrl #(
    .MAX_LEAVES (MAX_LEAVES),
    .AW         (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (leaf_i.valid),
    .in_ready_o  (leaf_i.ready),
    .out_valid_o (node_o.valid),
    .out_ready_i (node_o.ready),
    .out_level_o (node_o.node_level),
    .out_root_o  (node_o.is_root),
    .cmd_o       (cmd),
    .addr_o      (addr),
    .stat_i      (stat)
  );

  mktr_datapath #(
    .MAX_LEAVES (MAX_LEAVES),
    .AW         (AW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .leaf_word_i (leaf_word),
    .stat_o      (stat),
    .node_word_o (node_word)
  );

  assign node_o.node_word0 = node_word[0];
  assign node_o.node_word1 = node_word[1];
  assign node_o.node_word2 = node_word[2];
  assign node_o.node_word3 = node_word[3];

endmodule

### tb/testbench.sv
module testbench;

  localparam int QUIET_LIMIT = 6000;

  typedef struct {
    logic [255:0]                 hash;
    logic [mktr_pkg::LEVEL_W-1:0] level;
    logic                         root;
  } tree_node_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [mktr_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mktr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  mktr_leaf_if leaf_if ();
  mktr_node_if node_if ();

  merkle_tree_root_and_auth_path i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .leaf_i     (leaf_if),
    .node_o     (node_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the block's state
  logic [255:0]                  tree_store [16];
  int unsigned                   leaves_held;
  logic [mktr_pkg::HEIGHT_W-1:0] tree_height;
  logic [mktr_pkg::SEL_W-1:0]    path_leaf;

  logic [255:0] leaves_to_send [$];
  tree_node_t   nodes_due [$];
  int           errors;
  bit           calm;
  bit           want_long_stall;
  bit           leaf_taken;
  int           src_gap;
  int           sink_gap;
  int           quiet;
  int           sent;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(logic [255:0] st, logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    logic [255:0] res;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = st[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + mktr_pkg::SHA_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32*i -: 32] = st[255 - 32*i -: 32] + v[i];
    return res;
  endfunction

  function automatic logic [255:0] parent_hash(logic [255:0] left, logic [255:0] right);
    logic [255:0] iv;
    logic [511:0] pad;
    for (int i = 0; i < 8; i++) iv[255 - 32*i -: 32] = mktr_pkg::SHA_IV[i];
    pad = '0;
    pad[511 -: 32] = 32'h80000000;
    pad[31:0] = 32'd512;
    return sha_compress(sha_compress(iv, {left, right}), pad);
  endfunction

  task automatic take_leaf(logic [255:0] leaf);
    int unsigned h, count, idx, width;
    tree_node_t n;
    h = (tree_height > 4) ? 4 : tree_height;
    count = 1 << h;
    if (leaves_held < 16) begin
      tree_store[leaves_held] = leaf;
      leaves_held++;
    end
    if (leaves_held < count) return;
    idx = path_leaf & (count - 1);
    width = count;
    for (int lvl = 0; lvl < h; lvl++) begin
      n.hash = tree_store[idx ^ 1];
      n.level = mktr_pkg::LEVEL_W'(lvl);
      n.root = 1'b0;
      nodes_due.push_back(n);
      width >>= 1;
      for (int i = 0; i < width; i++)
        tree_store[i] = parent_hash(tree_store[2*i], tree_store[2*i+1]);
      idx >>= 1;
    end
    n.hash = tree_store[0];
    n.level = mktr_pkg::LEVEL_W'(h);
    n.root = 1'b1;
    nodes_due.push_back(n);
    leaves_held = 0;
  endtask

  // leaf source
  always @(posedge clk_i) begin
    if (rst_ni && leaf_if.valid && leaf_if.ready) begin
      take_leaf(leaves_to_send.pop_front());
      leaf_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    logic v;
    if (rst_ni) begin
      if ((leaf_taken || !leaf_if.valid) && !calm && src_gap == 0 &&
          $urandom_range(0, 7) == 0)
        src_gap = $urandom_range(1, 19);
      leaf_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        v = 1'b0;
      end else begin
        v = leaves_to_send.size() > 0;
      end
      leaf_if.valid <= v;
      if (v) begin
        leaf_if.leaf_word0 <= leaves_to_send[0][255:192];
        leaf_if.leaf_word1 <= leaves_to_send[0][191:128];
        leaf_if.leaf_word2 <= leaves_to_send[0][127:64];
        leaf_if.leaf_word3 <= leaves_to_send[0][63:0];
      end
    end
  end

  // node sink
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (want_long_stall) begin
        sink_gap = 700;
        want_long_stall = 1'b0;
      end else if (sink_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(1, 19);
      end
      if (sink_gap > 0) sink_gap--;
      node_if.ready <= (sink_gap == 0);
    end
  end

  always @(posedge clk_i) begin
    tree_node_t n;
    logic [255:0] got;
    if (rst_ni && node_if.valid && node_if.ready) begin
      if (nodes_due.size() == 0) begin
        $error("node transaction with nothing expected");
        errors++;
      end else begin
        n = nodes_due.pop_front();
        got = {node_if.node_word0, node_if.node_word1, node_if.node_word2, node_if.node_word3};
        for (int i = 0; i < 4; i++)
          if (got[255 - 64*i -: 64] !== n.hash[255 - 64*i -: 64]) begin
            $error("node_word%0d: expected %h, got %h", i, n.hash[255 - 64*i -: 64],
                   got[255 - 64*i -: 64]);
            errors++;
          end
        if (node_if.node_level !== n.level) begin
          $error("node_level: expected %0d, got %0d", n.level, node_if.node_level);
          errors++;
        end
        if (node_if.is_root !== n.root) begin
          $error("is_root: expected %0d, got %0d", n.root, node_if.is_root);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((leaf_if.valid && leaf_if.ready) || (node_if.valid && node_if.ready) || !rst_ni)
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_leaves(int n);
    for (int i = 0; i < n; i++) begin
      leaves_to_send.push_back({rand_word(), rand_word(), rand_word(), rand_word()});
      sent++;
    end
  endtask

  task automatic drain();
    do @(negedge clk_i); while (leaves_to_send.size() != 0 || nodes_due.size() != 0);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [mktr_pkg::CFG_IDX_W-1:0] idx,
                           logic [mktr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == mktr_pkg::REG_LEAF_COUNT_LOG2) tree_height = data[mktr_pkg::HEIGHT_W-1:0];
    else path_leaf = data[mktr_pkg::SEL_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [mktr_pkg::CFG_DATA_W-1:0] hdata;
    int phase, trees, eff;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    leaf_if.valid = 1'b0;
    leaf_if.leaf_word0 = '0; leaf_if.leaf_word1 = '0;
    leaf_if.leaf_word2 = '0; leaf_if.leaf_word3 = '0;
    node_if.ready = 1'b0;
    tree_height = mktr_pkg::RST_LEAF_COUNT_LOG2;
    path_leaf = mktr_pkg::RST_SELECTED_LEAF;
    leaves_held = 0;
    errors = 0; sent = 0; quiet = 0; src_gap = 0; sink_gap = 0;
    calm = 1'b0; want_long_stall = 1'b0; leaf_taken = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: full 16-leaf tree with all-zero and all-one leaves first
    leaves_to_send.push_back('0);
    leaves_to_send.push_back('1);
    sent += 2;
    queue_leaves(14);
    drain();
    // single leaf: each leaf is its own root
    write_reg(mktr_pkg::REG_LEAF_COUNT_LOG2, 4'd0);
    queue_leaves(2);
    drain();
    // height lowered part way through a load
    write_reg(mktr_pkg::REG_LEAF_COUNT_LOG2, 4'd4);
    write_reg(mktr_pkg::REG_SELECTED_LEAF, 4'd15);
    queue_leaves(3);
    drain();
    write_reg(mktr_pkg::REG_LEAF_COUNT_LOG2, 4'd1);
    queue_leaves(1);
    drain();
    // oversized height clamps to four, selected leaf at the top of its range
    write_reg(mktr_pkg::REG_LEAF_COUNT_LOG2, 4'd7);
    queue_leaves(16);
    drain();

    phase = 0;
    while (sent < 400) begin
      hdata = 4'($urandom_range(0, 15));
      if (hdata[2:0] >= 3 && $urandom_range(0, 2) != 0)
        hdata = {hdata[3], 3'($urandom_range(0, 2))};
      if (phase == 4) hdata = 4'd2;
      write_reg(mktr_pkg::REG_LEAF_COUNT_LOG2, hdata);
      write_reg(mktr_pkg::REG_SELECTED_LEAF, 4'($urandom_range(0, 15)));
      eff = (hdata[2:0] > 4) ? 4 : hdata[2:0];
      trees = (phase == 4) ? 4 : $urandom_range(1, 3);
      if (sent > 340) calm = 1'b1;
      // long sink hold-off while leaves keep coming: the block backs up
      if (phase == 4) want_long_stall = 1'b1;
      queue_leaves(trees << eff);
      drain();
      phase++;
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
rtl/mktr_pkg.sv
rtl/mktr_leaf_if.sv
rtl/mktr_node_if.sv
rtl/mktr_ram.sv
rtl/mktr_sha_core.sv
rtl/mktr_datapath.sv
rtl/mktr_ctrl.sv
rtl/merkle_tree_root_and_auth_path.sv
tb/testbench.sv
